// ===== rtl/core/alcd_pkg.sv =====
// ----------------------------------------------------------------------------
// alcd_pkg
// shared types, codes and constants of the addressable led chain driver
// ----------------------------------------------------------------------------
`default_nettype none

package alcd_pkg;

    localparam int LedCount   = 16;
    localparam int LedIdxW    = (LedCount > 1) ? $clog2(LedCount) : 1;
    localparam int ColorW     = 24;
    localparam int BitsPerLed = 24;
    localparam int BitIdxW    = 5;
    localparam int SlotW      = 10;
    localparam int TickW      = 8;
    localparam int ResetTickW = 10;
    localparam int ModeW      = 3;
    localparam int IndexW     = 8;
    localparam int StatusW    = 2;
    localparam int CfgIdxW    = 2;
    localparam int CfgDataW   = 10;

    localparam logic [ModeW-1:0] MODE_TICK    = 3'd0;
    localparam logic [ModeW-1:0] MODE_SET_ONE = 3'd1;
    localparam logic [ModeW-1:0] MODE_SET_ALL = 3'd2;
    localparam logic [ModeW-1:0] MODE_SHIFT   = 3'd3;
    localparam logic [ModeW-1:0] MODE_FRAME   = 3'd4;
    localparam logic [ModeW-1:0] MODE_RESET   = 3'd5;

    localparam logic [StatusW-1:0] STAT_OK     = 2'd0;
    localparam logic [StatusW-1:0] STAT_BUSY   = 2'd1;
    localparam logic [StatusW-1:0] STAT_RANGE  = 2'd2;
    localparam logic [StatusW-1:0] STAT_ZERO   = 2'd3;

    localparam logic [CfgIdxW-1:0] CFG_BIT_TICKS   = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_ONE_HIGH    = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_ZERO_HIGH   = 2'd2;
    localparam logic [CfgIdxW-1:0] CFG_RESET_TICKS = 2'd3;

    localparam logic [TickW-1:0]      BitTicksRst   = 8'd5;
    localparam logic [TickW-1:0]      OneHighRst    = 8'd4;
    localparam logic [TickW-1:0]      ZeroHighRst   = 8'd1;
    localparam logic [ResetTickW-1:0] ResetTicksRst = 10'd300;

    typedef struct packed {
        logic               wr_one;
        logic               wr_all;
        logic               shift;
        logic               start_frame;
        logic               start_reset;
        logic [StatusW-1:0] status;
    } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/alcd_cmd.sv =====
// ----------------------------------------------------------------------------
// alcd_cmd
// command decode with busy, range and zero colour checks
// ----------------------------------------------------------------------------
`default_nettype none

module alcd_cmd
    import alcd_pkg::*;
(
    input  wire logic [ModeW-1:0]  mode,
    input  wire logic [IndexW-1:0] led_index,
    input  wire logic [ColorW-1:0] color,
    input  wire logic              busy,
    output cmd_t                   cmd
);

    always_comb begin
        cmd = '0;
        cmd.status = STAT_OK;
        case (mode)
            MODE_SET_ONE, MODE_SET_ALL, MODE_SHIFT, MODE_FRAME, MODE_RESET: begin
                if (busy) begin
                    cmd.status = STAT_BUSY;
                end else begin
                    case (mode)
                        MODE_SET_ONE: begin
                            if ({1'b0, led_index} < (IndexW+1)'(LedCount)) begin
                                cmd.wr_one = 1'b1;
                            end else begin
                                cmd.status = STAT_RANGE;
                            end
                        end
                        MODE_SET_ALL: begin
                            cmd.wr_all      = 1'b1;
                            cmd.start_frame = 1'b1;
                        end
                        MODE_SHIFT: begin
                            if (color == '0) begin
                                cmd.status = STAT_ZERO;
                            end else begin
                                cmd.shift       = 1'b1;
                                cmd.start_frame = 1'b1;
                            end
                        end
                        MODE_FRAME: begin
                            cmd.start_frame = 1'b1;
                        end
                        default: begin
                            cmd.start_reset = 1'b1;
                        end
                    endcase
                end
            end
            default: begin
                cmd.status = STAT_OK;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/alcd_store.sv =====
// ----------------------------------------------------------------------------
// alcd_store
// per-led colour registers with set one, set all and shift in
// ----------------------------------------------------------------------------
`default_nettype none

module alcd_store
    import alcd_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               accept,
    input  wire cmd_t               cmd,
    input  wire logic [LedIdxW-1:0] led_index,
    input  wire logic [ColorW-1:0]  color,
    input  wire logic [LedIdxW-1:0] rd_idx,
    output logic      [ColorW-1:0]  rd_word
);

    logic [ColorW-1:0] colour_reg  [LedCount];
    logic [ColorW-1:0] colour_next [LedCount];

    always_comb begin
        for (int n = 0; n < LedCount; n++) begin
            colour_next[n] = colour_reg[n];
        end
        if (cmd.wr_all) begin
            for (int n = 0; n < LedCount; n++) begin
                colour_next[n] = color;
            end
        end else if (cmd.shift) begin
            for (int n = 1; n < LedCount; n++) begin
                colour_next[n] = colour_reg[n-1];
            end
            colour_next[0] = color;
        end else if (cmd.wr_one) begin
            colour_next[led_index] = color;
        end
    end

    // the frame that starts with this transaction already sees the new colours
    assign rd_word = colour_next[rd_idx];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int n = 0; n < LedCount; n++) begin
                colour_reg[n] <= '0;
            end
        end else if (accept) begin
            for (int n = 0; n < LedCount; n++) begin
                colour_reg[n] <= colour_next[n];
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/alcd_seq.sv =====
// ----------------------------------------------------------------------------
// alcd_seq
// frame and reset pulse sequencer with led, bit and slot counters
// ----------------------------------------------------------------------------
`default_nettype none

module alcd_seq
    import alcd_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  accept,
    input  wire cmd_t                  cmd,
    input  wire logic [TickW-1:0]      bit_ticks,
    input  wire logic [TickW-1:0]      one_high_ticks,
    input  wire logic [TickW-1:0]      zero_high_ticks,
    input  wire logic [ResetTickW-1:0] reset_ticks,
    input  wire logic [ColorW-1:0]     rd_word,
    output logic      [LedIdxW-1:0]    rd_idx,
    output logic                       busy,
    output logic                       line,
    output logic                       busy_res,
    output logic                       frame_done
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_FRAME,
        PH_RESET
    } phase_t;

    phase_t               phase_reg, phase_eff, phase_next;
    logic [LedIdxW-1:0]   led_reg, led_eff, led_next;
    logic [BitIdxW-1:0]   bit_reg, bit_eff, bit_next;
    logic [SlotW-1:0]     slot_reg, slot_eff, slot_next;
    logic [SlotW:0]       slot_inc;
    logic [TickW-1:0]     high_ticks;
    logic                 data_bit;

    assign busy = (phase_reg != PH_IDLE);

    always_comb begin
        if (cmd.start_frame) begin
            phase_eff = PH_FRAME;
        end else if (cmd.start_reset) begin
            phase_eff = PH_RESET;
        end else begin
            phase_eff = phase_reg;
        end
        if (cmd.start_frame || cmd.start_reset) begin
            led_eff  = '0;
            bit_eff  = '0;
            slot_eff = '0;
        end else begin
            led_eff  = led_reg;
            bit_eff  = bit_reg;
            slot_eff = slot_reg;
        end
    end

    assign rd_idx     = led_eff;
    assign data_bit   = rd_word[bit_eff];
    assign high_ticks = data_bit ? one_high_ticks : zero_high_ticks;
    assign slot_inc   = {1'b0, slot_eff} + (SlotW+1)'(1);

    always_comb begin
        phase_next = phase_eff;
        led_next   = led_eff;
        bit_next   = bit_eff;
        slot_next  = slot_eff;
        line       = 1'b0;
        busy_res   = 1'b0;
        frame_done = 1'b0;
        case (phase_eff)
            PH_FRAME: begin
                busy_res = 1'b1;
                line     = (slot_eff < SlotW'(high_ticks));
                if (slot_inc >= (SlotW+1)'(bit_ticks)) begin
                    slot_next = '0;
                    if ((BitIdxW+1)'(bit_eff) + (BitIdxW+1)'(1) >= (BitIdxW+1)'(BitsPerLed)) begin
                        bit_next = '0;
                        if ((LedIdxW+1)'(led_eff) + (LedIdxW+1)'(1)
                                >= (LedIdxW+1)'(LedCount)) begin
                            led_next   = '0;
                            phase_next = PH_IDLE;
                            frame_done = 1'b1;
                        end else begin
                            led_next = led_eff + LedIdxW'(1);
                        end
                    end else begin
                        bit_next = bit_eff + BitIdxW'(1);
                    end
                end else begin
                    slot_next = slot_inc[SlotW-1:0];
                end
            end
            PH_RESET: begin
                busy_res = 1'b1;
                if (slot_inc >= (SlotW+1)'(reset_ticks)) begin
                    slot_next  = '0;
                    phase_next = PH_IDLE;
                    frame_done = 1'b1;
                end else begin
                    slot_next = slot_inc[SlotW-1:0];
                end
            end
            default: begin
                busy_res = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            led_reg   <= '0;
            bit_reg   <= '0;
            slot_reg  <= '0;
        end else if (accept) begin
            phase_reg <= phase_next;
            led_reg   <= led_next;
            bit_reg   <= bit_next;
            slot_reg  <= slot_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/addressable_led_chain_driver.sv =====
// ----------------------------------------------------------------------------
// addressable_led_chain_driver
// one-wire rgb led chain driver: colour store, frame serializer, result register
// ----------------------------------------------------------------------------
// a transaction's result is registered and shown on the m_ port in the cycle after acceptance
// throughput: one transaction per cycle while m_ready takes the results, set by the single result register
// s_ready stays high while the result register is empty or being taken
// reset: synchronous active-low aresetn clears colours, sequencer and config
// to their defaults and empties the result register
// ----------------------------------------------------------------------------
`default_nettype none

module addressable_led_chain_driver
    import alcd_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_we,
    input  wire logic [CfgIdxW-1:0]  cfg_index,
    input  wire logic [CfgDataW-1:0] cfg_wdata,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [ModeW-1:0]    s_mode,
    input  wire logic [IndexW-1:0]   s_led_index,
    input  wire logic [ColorW-1:0]   s_color,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic                     m_line,
    output logic                     m_busy_res,
    output logic [StatusW-1:0]       m_status,
    output logic                     m_frame_done
);

    logic [TickW-1:0]      bit_ticks_reg;
    logic [TickW-1:0]      one_high_reg;
    logic [TickW-1:0]      zero_high_reg;
    logic [ResetTickW-1:0] reset_ticks_reg;

    logic                  accept;
    logic                  busy;
    cmd_t                  cmd;
    logic [LedIdxW-1:0]    rd_idx;
    logic [ColorW-1:0]     rd_word;
    logic                  line;
    logic                  busy_res;
    logic                  frame_done;

    logic                  m_valid_reg;
    logic                  line_reg;
    logic                  busy_res_reg;
    logic [StatusW-1:0]    status_reg;
    logic                  frame_done_reg;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_ticks_reg   <= BitTicksRst;
            one_high_reg    <= OneHighRst;
            zero_high_reg   <= ZeroHighRst;
            reset_ticks_reg <= ResetTicksRst;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_BIT_TICKS:   bit_ticks_reg   <= cfg_wdata[TickW-1:0];
                CFG_ONE_HIGH:    one_high_reg    <= cfg_wdata[TickW-1:0];
                CFG_ZERO_HIGH:   zero_high_reg   <= cfg_wdata[TickW-1:0];
                CFG_RESET_TICKS: reset_ticks_reg <= cfg_wdata[ResetTickW-1:0];
                default:         bit_ticks_reg   <= bit_ticks_reg;
            endcase
        end
    end

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    alcd_cmd u_cmd (
        .mode      (s_mode),
        .led_index (s_led_index),
        .color     (s_color),
        .busy      (busy),
        .cmd       (cmd)
    );

    alcd_store u_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .cmd       (cmd),
        .led_index (s_led_index[LedIdxW-1:0]),
        .color     (s_color),
        .rd_idx    (rd_idx),
        .rd_word   (rd_word)
    );

    alcd_seq u_seq (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .accept          (accept),
        .cmd             (cmd),
        .bit_ticks       (bit_ticks_reg),
        .one_high_ticks  (one_high_reg),
        .zero_high_ticks (zero_high_reg),
        .reset_ticks     (reset_ticks_reg),
        .rd_word         (rd_word),
        .rd_idx          (rd_idx),
        .busy            (busy),
        .line            (line),
        .busy_res        (busy_res),
        .frame_done      (frame_done)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            line_reg       <= line;
            busy_res_reg   <= busy_res;
            status_reg     <= cmd.status;
            frame_done_reg <= frame_done;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_line       = line_reg;
    assign m_busy_res   = busy_res_reg;
    assign m_status     = status_reg;
    assign m_frame_done = frame_done_reg;

    // a completed frame or pulse is always reported on a busy tick
    a_done_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_done |-> m_busy_res)
        else $error("frame_done without busy_res");

    // a command refused for busy means a frame or pulse owns this tick
    a_refused_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == STAT_BUSY) |-> m_busy_res)
        else $error("busy status on an idle tick");

    // the line is only driven high inside a frame
    a_line_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_line |-> m_busy_res)
        else $error("line high while idle");

    // a transaction taken on an idle sequencer with no start command stays idle
    a_idle_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !busy && !cmd.start_frame && !cmd.start_reset |=> !m_busy_res)
        else $error("busy result without a start");

endmodule

`default_nettype wire
